FILE: hw/rtl/gppa_pkg.sv
// Shared types and constants of the generational page pool allocator.
package gppa_pkg;

    localparam int unsigned POOL_PAGES_DEF = 256;
    localparam int unsigned LAYER_LIMIT    = 43;
    localparam logic [7:0]  KIND_RESET     = 8'd4;
    localparam int unsigned CNT_W          = 9;

    typedef enum logic [3:0] {
        CMD_RESERVE       = 4'd0,
        CMD_RESERVE_COW   = 4'd1,
        CMD_PUBLISH       = 4'd2,
        CMD_CHK_PUBLISH   = 4'd3,
        CMD_FIND          = 4'd4,
        CMD_CHK_COW_PUB   = 4'd5,
        CMD_COW_PUBLISH   = 4'd6,
        CMD_ROLLBACK      = 4'd7,
        CMD_RELEASE       = 4'd8,
        CMD_CHK_SEQ_REL   = 4'd9,
        CMD_SEQ_RELEASE   = 4'd10
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_INVALID   = 2'd1,
        STS_PRECOND   = 2'd2,
        STS_EXHAUSTED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_FREE      = 2'd0,
        ST_RESERVED  = 2'd1,
        ST_PUBLISHED = 2'd2
    } t_slot_st;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CHK_A,
        S_CHK_B,
        S_WR2,
        S_SCAN,
        S_SDONE,
        S_SCAN2
    } t_fsm;

    typedef struct packed {
        logic [31:0] gen;
        logic [31:0] seq;
        logic [5:0]  layer;
        logic [31:0] page;
        t_slot_st    st;
    } t_slot_rec;

    typedef struct packed {
        logic [3:0]  command;
        logic [31:0] sequence_req;
        logic [7:0]  layer_index;
        logic [31:0] page_num;
        logic [63:0] page_handle;
        logic [31:0] repl_sequence;
        logic [7:0]  repl_layer;
        logic [31:0] repl_page;
        logic [63:0] repl_handle;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic             found;
        logic [63:0]      out_handle;
        logic [31:0]      out_sequence;
        logic [5:0]       out_layer;
        logic [31:0]      out_page_num;
        logic [CNT_W-1:0] free_total;
        logic [CNT_W-1:0] reserved_total;
        logic [CNT_W-1:0] published_total;
    } t_res;

endpackage

FILE: hw/rtl/gppa_slot_mem.sv
// Slot record memory: one write port, one registered read port, per-entry valid bits.
module gppa_slot_mem #(
    parameter int unsigned POOL_PAGES = 256,
    parameter int unsigned AW         = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [AW-1:0]        i_rd_addr,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  gppa_pkg::t_slot_rec  i_wr_data,
    output gppa_pkg::t_slot_rec  o_rd_data
);
    import gppa_pkg::*;

    t_slot_rec             r_mem [POOL_PAGES];
    t_slot_rec             r_rd;
    logic [POOL_PAGES-1:0] r_vld;
    logic                  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    // entries never written read as the reset record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd : '0;

endmodule

FILE: hw/rtl/gppa_cfg.sv
// APB register block holding the page kind code.
module gppa_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  o_kind
);
    import gppa_pkg::*;

    logic [7:0] r_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_kind <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {24'd0, r_kind};
    assign o_kind = r_kind;

endmodule

FILE: hw/rtl/generational_page_pool_allocator_unit.sv
// Top level: command sequencer of the generational page pool allocator.
//
// Usage: drive a command word on i_item and raise start while busy is low; the
// word is taken at that edge. Exactly one result word follows on o_result,
// marked by o_result_valid for one cycle; busy falls in that same cycle, so a
// new command may be started right then. The receiver cannot stall results.
// A command word that is itself rejected is answered from decode. Commands that
// check one handle read its slot; check cow publish and cow publish also check
// the replacement handle, and cow publish then writes a second slot. Reserve,
// reserve cow, find and check seq release sweep the slot memory one slot per
// cycle; seq release sweeps a second time, to free the pages, when the first
// sweep finds no reserved page of its sequence. The single read port of the
// slot memory sets this rate; the next command may start in the result cycle.
// Reset: all slots free with generation zero, free count at the pool size,
// other counts cleared, kind code 4. Slot records read as zero until first
// written; no clearing pass is needed. The user writes the kind code over the
// APB port only while the block is idle; the block itself does not enforce it.
module generational_page_pool_allocator_unit #(
    parameter int unsigned POOL_PAGES = gppa_pkg::POOL_PAGES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  gppa_pkg::t_req i_item,
    output logic           o_result_valid,
    output gppa_pkg::t_res o_result,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import gppa_pkg::*;

    localparam int unsigned AW = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(POOL_PAGES - 1);
    localparam logic [24:0]   POOL_LIM = 25'(POOL_PAGES);

    t_fsm             r_state, n_state;
    t_req             r_req;
    t_res             r_res, n_res;
    logic             r_stb, n_stb;
    logic [AW-1:0]    r_idx, n_idx, r_pidx, n_pidx, r_fidx, n_fidx;
    logic             r_iss, n_iss, r_pv, n_pv;
    logic             r_hit, n_hit, r_ff, n_ff, r_spent, n_spent;
    logic [31:0]      r_fgen, n_fgen;
    t_slot_st         r_fst, n_fst;
    t_slot_rec        r_srec, n_srec;
    logic [CNT_W-1:0] r_free, n_free, r_rsv, n_rsv, r_pub, n_pub;

    logic [7:0]    kind;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    t_slot_rec     wr_data, rd;

    logic [3:0]    cmd;
    logic          id_bad, hbad_a, hbad_b, ok_a, ok_b, cow_bad, idm, last;
    logic          enter_scan;
    logic [AW-1:0] s_slot, t_slot;
    t_slot_st      exp_a;

    gppa_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_kind  (kind)
    );

    gppa_slot_mem #(
        .POOL_PAGES (POOL_PAGES),
        .AW         (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd)
    );

    // decode and checks on the held command word and the slot just read
    always_comb begin
        cmd     = r_req.command;
        s_slot  = r_req.page_handle[32 +: AW];
        t_slot  = r_req.repl_handle[32 +: AW];
        id_bad  = (r_req.sequence_req == 32'd0) || (r_req.layer_index >= 8'(LAYER_LIMIT));
        hbad_a  = (r_req.page_handle[63:56] != kind) ||
                  ({1'b0, r_req.page_handle[55:32]} >= POOL_LIM);
        hbad_b  = (r_req.repl_handle[63:56] != kind) ||
                  ({1'b0, r_req.repl_handle[55:32]} >= POOL_LIM);
        exp_a   = (cmd inside {CMD_PUBLISH, CMD_CHK_PUBLISH, CMD_ROLLBACK}) ?
                  ST_RESERVED : ST_PUBLISHED;
        ok_a    = (rd.gen == r_req.page_handle[31:0]) && (rd.seq == r_req.sequence_req) &&
                  ({2'b00, rd.layer} == r_req.layer_index) &&
                  (rd.page == r_req.page_num) && (rd.st == exp_a);
        ok_b    = (rd.gen == r_req.repl_handle[31:0]) && (rd.seq == r_req.repl_sequence) &&
                  ({2'b00, rd.layer} == r_req.repl_layer) &&
                  (rd.page == r_req.repl_page) && (rd.st == ST_RESERVED);
        cow_bad = (s_slot == t_slot) || (r_req.sequence_req != r_req.repl_sequence) ||
                  (r_req.layer_index != r_req.repl_layer) ||
                  (r_req.page_num != r_req.repl_page);
        idm     = (rd.seq == r_req.sequence_req) && ({2'b00, rd.layer} == r_req.layer_index) &&
                  (rd.page == r_req.page_num);
        last    = r_pv && (r_pidx == LAST_IDX);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_DECODE;
            end
            S_DECODE: begin
                n_state = S_IDLE;
                if (cmd inside {CMD_RESERVE, CMD_FIND}) begin
                    if (!id_bad && !(cmd == CMD_RESERVE && r_spent)) n_state = S_SCAN;
                end else if (cmd inside {CMD_CHK_SEQ_REL, CMD_SEQ_RELEASE}) begin
                    if (r_req.sequence_req != 32'd0) n_state = S_SCAN;
                end else if (cmd inside {[CMD_RESERVE_COW:CMD_CHK_PUBLISH],
                                         [CMD_CHK_COW_PUB:CMD_RELEASE]}) begin
                    if (!hbad_a) n_state = S_CHK_A;
                end
            end
            S_CHK_A: begin
                n_state = S_IDLE;
                if (ok_a) begin
                    if (cmd == CMD_RESERVE_COW && !r_spent) n_state = S_SCAN;
                    if (cmd inside {CMD_CHK_COW_PUB, CMD_COW_PUBLISH} && !hbad_b)
                        n_state = S_CHK_B;
                end
            end
            S_CHK_B: begin
                n_state = (ok_b && !cow_bad && cmd == CMD_COW_PUBLISH) ? S_WR2 : S_IDLE;
            end
            S_WR2:   n_state = S_IDLE;
            S_SCAN: begin
                if (last) n_state = S_SDONE;
            end
            S_SDONE: begin
                n_state = (cmd == CMD_SEQ_RELEASE && !r_hit) ? S_SCAN2 : S_IDLE;
            end
            S_SCAN2: begin
                if (last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath, memory control and result
    always_comb begin
        n_res      = '0;
        n_stb      = 1'b0;
        n_idx      = r_idx;
        n_iss      = 1'b0;
        n_pv       = 1'b0;
        n_pidx     = r_idx;
        n_hit      = r_hit;
        n_ff       = r_ff;
        n_fidx     = r_fidx;
        n_fgen     = r_fgen;
        n_fst      = r_fst;
        n_srec     = r_srec;
        n_spent    = r_spent;
        n_free     = r_free;
        n_rsv      = r_rsv;
        n_pub      = r_pub;
        rd_addr    = s_slot;
        wr_en      = 1'b0;
        wr_addr    = s_slot;
        wr_data    = rd;
        enter_scan = (n_state == S_SCAN || n_state == S_SCAN2) &&
                     !(r_state == S_SCAN || r_state == S_SCAN2);
        n_res.status = STS_OK;

        case (r_state)
            S_DECODE: begin
                rd_addr = s_slot;
                if (n_state == S_IDLE) begin
                    n_stb = 1'b1;
                    n_res.status = (cmd == CMD_RESERVE && !id_bad && r_spent) ?
                                   STS_PRECOND : STS_INVALID;
                end
            end
            S_CHK_A: begin
                rd_addr = t_slot;
                n_srec  = rd;
                if (n_state == S_IDLE) begin
                    n_stb = 1'b1;
                    if (!ok_a || cmd == CMD_RESERVE_COW) begin
                        n_res.status = STS_PRECOND;
                    end else if (cmd inside {CMD_CHK_COW_PUB, CMD_COW_PUBLISH}) begin
                        n_res.status = STS_INVALID;
                    end else if (cmd == CMD_PUBLISH) begin
                        wr_en      = 1'b1;
                        wr_data.st = ST_PUBLISHED;
                        n_pub      = r_pub + 1'b1;
                        n_rsv      = r_rsv - 1'b1;
                    end else if (cmd == CMD_ROLLBACK) begin
                        wr_en      = 1'b1;
                        wr_data.st = ST_FREE;
                        n_free     = r_free + 1'b1;
                        n_rsv      = r_rsv - 1'b1;
                    end else if (cmd == CMD_RELEASE) begin
                        wr_en      = 1'b1;
                        wr_data.st = ST_FREE;
                        n_free     = r_free + 1'b1;
                        n_pub      = r_pub - 1'b1;
                    end
                end
            end
            S_CHK_B: begin
                if (n_state == S_IDLE) begin
                    n_stb = 1'b1;
                    if (!ok_b) n_res.status = STS_PRECOND;
                    else if (cow_bad) n_res.status = STS_INVALID;
                end else begin
                    // replacement goes live first, the source frees next cycle
                    wr_en      = 1'b1;
                    wr_addr    = t_slot;
                    wr_data.st = ST_PUBLISHED;
                end
            end
            S_WR2: begin
                wr_en      = 1'b1;
                wr_data    = r_srec;
                wr_data.st = ST_FREE;
                n_rsv      = r_rsv - 1'b1;
                n_free     = r_free + 1'b1;
                n_stb      = 1'b1;
            end
            S_SCAN: begin
                rd_addr = r_idx;
                n_pv    = r_iss;
                n_pidx  = r_idx;
                if (r_iss && r_idx != LAST_IDX) begin
                    n_iss = 1'b1;
                    n_idx = r_idx + 1'b1;
                end
                if (r_pv) begin
                    if (cmd inside {CMD_RESERVE, CMD_RESERVE_COW}) begin
                        if (cmd == CMD_RESERVE && rd.st != ST_FREE && idm) n_hit = 1'b1;
                        if (rd.st == ST_FREE && !r_ff) begin
                            n_ff   = 1'b1;
                            n_fidx = r_pidx;
                            n_fgen = rd.gen;
                        end
                    end else if (cmd == CMD_FIND) begin
                        if (rd.st != ST_FREE && idm && !r_ff) begin
                            n_ff   = 1'b1;
                            n_fidx = r_pidx;
                            n_fgen = rd.gen;
                            n_fst  = rd.st;
                        end
                    end else begin
                        if (rd.seq == r_req.sequence_req && rd.st == ST_RESERVED) n_hit = 1'b1;
                    end
                end
            end
            S_SDONE: begin
                wr_addr = r_fidx;
                if (n_state == S_IDLE) n_stb = 1'b1;
                if (cmd inside {CMD_RESERVE, CMD_RESERVE_COW}) begin
                    if (r_hit) begin
                        n_res.status = STS_PRECOND;
                    end else if (!r_ff) begin
                        n_res.status = STS_EXHAUSTED;
                    end else if (r_fgen == 32'hFFFF_FFFF) begin
                        n_spent      = 1'b1;
                        n_res.status = STS_PRECOND;
                    end else begin
                        wr_en              = 1'b1;
                        wr_data.gen        = r_fgen + 32'd1;
                        wr_data.seq        = r_req.sequence_req;
                        wr_data.layer      = r_req.layer_index[5:0];
                        wr_data.page       = r_req.page_num;
                        wr_data.st         = ST_RESERVED;
                        n_free             = r_free - 1'b1;
                        n_rsv              = r_rsv + 1'b1;
                        n_res.found        = 1'b1;
                        n_res.out_handle   = {kind, 24'(r_fidx), r_fgen + 32'd1};
                        n_res.out_sequence = r_req.sequence_req;
                        n_res.out_layer    = r_req.layer_index[5:0];
                        n_res.out_page_num = r_req.page_num;
                    end
                end else if (cmd == CMD_FIND) begin
                    if (r_ff && r_fst != ST_PUBLISHED) begin
                        n_res.status = STS_PRECOND;
                    end else if (r_ff) begin
                        n_res.found        = 1'b1;
                        n_res.out_handle   = {kind, 24'(r_fidx), r_fgen};
                        n_res.out_sequence = r_req.sequence_req;
                        n_res.out_layer    = r_req.layer_index[5:0];
                        n_res.out_page_num = r_req.page_num;
                    end
                end else if (r_hit) begin
                    n_res.status = STS_PRECOND;
                end
            end
            S_SCAN2: begin
                rd_addr = r_idx;
                n_pv    = r_iss;
                n_pidx  = r_idx;
                wr_addr = r_pidx;
                if (r_iss && r_idx != LAST_IDX) begin
                    n_iss = 1'b1;
                    n_idx = r_idx + 1'b1;
                end
                // read of the next slot never hits the slot being freed
                if (r_pv && rd.seq == r_req.sequence_req && rd.st == ST_PUBLISHED) begin
                    wr_en      = 1'b1;
                    wr_data.st = ST_FREE;
                    n_pub      = r_pub - 1'b1;
                    n_free     = r_free + 1'b1;
                end
                if (last) n_stb = 1'b1;
            end
            default: ;
        endcase

        if (enter_scan) begin
            n_iss = 1'b1;
            n_idx = '0;
            n_pv  = 1'b0;
            n_hit = 1'b0;
            n_ff  = 1'b0;
        end

        n_res.free_total      = n_free;
        n_res.reserved_total  = n_rsv;
        n_res.published_total = n_pub;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stb   <= 1'b0;
            r_iss   <= 1'b0;
            r_pv    <= 1'b0;
            r_hit   <= 1'b0;
            r_ff    <= 1'b0;
            r_spent <= 1'b0;
            r_free  <= CNT_W'(POOL_PAGES);
            r_rsv   <= '0;
            r_pub   <= '0;
        end else begin
            r_state <= n_state;
            r_stb   <= n_stb;
            r_iss   <= n_iss;
            r_pv    <= n_pv;
            r_hit   <= n_hit;
            r_ff    <= n_ff;
            r_spent <= n_spent;
            r_free  <= n_free;
            r_rsv   <= n_rsv;
            r_pub   <= n_pub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) r_req <= i_item;
        if (n_stb) r_res <= n_res;
        r_idx  <= n_idx;
        r_pidx <= n_pidx;
        r_fidx <= n_fidx;
        r_fgen <= n_fgen;
        r_fst  <= n_fst;
        r_srec <= n_srec;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_stb;
    assign o_result       = r_res;

    a_cnt_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_free + r_rsv + r_pub) == CNT_W'(POOL_PAGES))
        else $error("slot counts do not add up to the pool size");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy && $past(busy))
        else $error("result word outside the end of a command");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.found |-> o_result.status == STS_OK)
        else $error("page returned with a failing status");

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DECODE |=> !o_result_valid || r_state == S_IDLE)
        else $error("result word while command still running");

endmodule

FILE: bench/generational_page_pool_allocator_unit_chk.sv
// Checker: predicts allocator results from accepted commands and compares them.
module generational_page_pool_allocator_unit_chk
    import gppa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  t_req        i_item,
    input  logic        i_result_valid,
    input  t_res        i_result,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_errors,
    output int          o_pending
);
    localparam int PAGES = 256;

    logic [31:0] gen_m [PAGES];
    logic [31:0] seq_m [PAGES];
    logic [5:0]  lay_m [PAGES];
    logic [31:0] pg_m  [PAGES];
    t_slot_st    st_m  [PAGES];
    int unsigned n_free, n_res, n_pub;
    logic        gen_spent;
    logic [7:0]  kind;
    t_res        expected_words[$];

    function automatic logic [63:0] pack_handle(int unsigned slot, logic [31:0] g);
        return {kind, slot[23:0], g};
    endfunction

    // returns status; slot found in idx
    function automatic t_status check_page(logic [63:0] h, logic [31:0] sq, logic [7:0] ly,
                                           logic [31:0] pg, t_slot_st want,
                                           output int unsigned idx);
        idx = h[55:32];
        if (h[63:56] != kind || h[55:32] >= PAGES) return STS_INVALID;
        if (gen_m[idx] != h[31:0] || seq_m[idx] != sq || {2'b0, lay_m[idx]} != ly ||
            pg_m[idx] != pg || st_m[idx] != want) return STS_PRECOND;
        return STS_OK;
    endfunction

    function automatic t_status take_free(t_req q, inout t_res r);
        for (int i = 0; i < PAGES; i++) begin
            if (st_m[i] != ST_FREE) continue;
            if (gen_m[i] == 32'hFFFF_FFFF) begin
                gen_spent = 1'b1;
                return STS_PRECOND;
            end
            gen_m[i]++;
            seq_m[i] = q.sequence_req;
            lay_m[i] = q.layer_index[5:0];
            pg_m[i] = q.page_num;
            st_m[i] = ST_RESERVED;
            n_free--;
            n_res++;
            r.found = 1'b1;
            r.out_handle = pack_handle(i, gen_m[i]);
            r.out_sequence = q.sequence_req;
            r.out_layer = q.layer_index[5:0];
            r.out_page_num = q.page_num;
            return STS_OK;
        end
        return STS_EXHAUSTED;
    endfunction

    function automatic t_status run_command(t_req q, inout t_res r);
        int unsigned s, t;
        t_status k;
        logic bad_id;
        bad_id = q.sequence_req == 0 || q.layer_index >= LAYER_LIMIT;
        case (q.command)
            CMD_RESERVE: begin
                if (bad_id) return STS_INVALID;
                if (gen_spent) return STS_PRECOND;
                for (int i = 0; i < PAGES; i++)
                    if (st_m[i] != ST_FREE && seq_m[i] == q.sequence_req &&
                        {2'b0, lay_m[i]} == q.layer_index && pg_m[i] == q.page_num)
                        return STS_PRECOND;
                return take_free(q, r);
            end
            CMD_RESERVE_COW: begin
                k = check_page(q.page_handle, q.sequence_req, q.layer_index,
                               q.page_num, ST_PUBLISHED, s);
                if (k != STS_OK) return k;
                if (gen_spent) return STS_PRECOND;
                return take_free(q, r);
            end
            CMD_PUBLISH, CMD_CHK_PUBLISH, CMD_ROLLBACK: begin
                k = check_page(q.page_handle, q.sequence_req, q.layer_index,
                               q.page_num, ST_RESERVED, s);
                if (k != STS_OK || q.command == CMD_CHK_PUBLISH) return k;
                if (q.command == CMD_PUBLISH) begin
                    st_m[s] = ST_PUBLISHED;
                    n_pub++;
                end else begin
                    st_m[s] = ST_FREE;
                    n_free++;
                end
                n_res--;
                return STS_OK;
            end
            CMD_FIND: begin
                if (bad_id) return STS_INVALID;
                for (int i = 0; i < PAGES; i++) begin
                    if (st_m[i] == ST_FREE || seq_m[i] != q.sequence_req ||
                        {2'b0, lay_m[i]} != q.layer_index || pg_m[i] != q.page_num)
                        continue;
                    if (st_m[i] != ST_PUBLISHED) return STS_PRECOND;
                    r.found = 1'b1;
                    r.out_handle = pack_handle(i, gen_m[i]);
                    r.out_sequence = q.sequence_req;
                    r.out_layer = q.layer_index[5:0];
                    r.out_page_num = q.page_num;
                    return STS_OK;
                end
                return STS_OK;
            end
            CMD_CHK_COW_PUB, CMD_COW_PUBLISH: begin
                k = check_page(q.page_handle, q.sequence_req, q.layer_index,
                               q.page_num, ST_PUBLISHED, s);
                if (k != STS_OK) return k;
                k = check_page(q.repl_handle, q.repl_sequence, q.repl_layer,
                               q.repl_page, ST_RESERVED, t);
                if (k != STS_OK) return k;
                if (s == t || q.sequence_req != q.repl_sequence ||
                    q.layer_index != q.repl_layer || q.page_num != q.repl_page)
                    return STS_INVALID;
                if (q.command == CMD_COW_PUBLISH) begin
                    st_m[s] = ST_FREE;
                    st_m[t] = ST_PUBLISHED;
                    n_res--;
                    n_free++;
                end
                return STS_OK;
            end
            CMD_RELEASE: begin
                k = check_page(q.page_handle, q.sequence_req, q.layer_index,
                               q.page_num, ST_PUBLISHED, s);
                if (k != STS_OK) return k;
                st_m[s] = ST_FREE;
                n_pub--;
                n_free++;
                return STS_OK;
            end
            CMD_CHK_SEQ_REL, CMD_SEQ_RELEASE: begin
                if (q.sequence_req == 0) return STS_INVALID;
                for (int i = 0; i < PAGES; i++)
                    if (seq_m[i] == q.sequence_req && st_m[i] == ST_RESERVED)
                        return STS_PRECOND;
                if (q.command == CMD_SEQ_RELEASE)
                    for (int i = 0; i < PAGES; i++)
                        if (seq_m[i] == q.sequence_req && st_m[i] == ST_PUBLISHED) begin
                            st_m[i] = ST_FREE;
                            n_pub--;
                            n_free++;
                        end
                return STS_OK;
            end
            default: return STS_INVALID;
        endcase
    endfunction

    function automatic t_res predict_word(t_req q);
        t_res r;
        t_status k;
        r = '0;
        k = run_command(q, r);
        if (k != STS_OK) r = '0;
        r.status = k;
        r.free_total = n_free[8:0];
        r.reserved_total = n_res[8:0];
        r.published_total = n_pub[8:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PAGES; i++) begin
                gen_m[i] = '0; seq_m[i] = '0; lay_m[i] = '0; pg_m[i] = '0;
                st_m[i] = ST_FREE;
            end
            n_free = PAGES; n_res = 0; n_pub = 0;
            gen_spent = 1'b0;
            kind = KIND_RESET;
            expected_words.delete();
            o_errors <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == 3'd0)
                kind = i_pwdata[7:0];
            if (i_result_valid) begin
                if (expected_words.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10) $display("unexpected result word %h", i_result);
                end else begin
                    t_res e;
                    e = expected_words.pop_front();
                    if (e != i_result) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10) begin
                            $display("mismatch: expected st=%0d f=%0d h=%h s=%h l=%0d p=%h %0d/%0d/%0d",
                                e.status, e.found, e.out_handle, e.out_sequence, e.out_layer,
                                e.out_page_num, e.free_total, e.reserved_total,
                                e.published_total);
                            $display("          got      st=%0d f=%0d h=%h s=%h l=%0d p=%h %0d/%0d/%0d",
                                i_result.status, i_result.found, i_result.out_handle,
                                i_result.out_sequence, i_result.out_layer,
                                i_result.out_page_num, i_result.free_total,
                                i_result.reserved_total, i_result.published_total);
                        end
                    end
                end
            end
            if (i_start && !i_busy) expected_words.push_back(predict_word(i_item));
        end
        o_pending <= expected_words.size();
    end
endmodule

FILE: bench/generational_page_pool_allocator_unit_tb.sv
// Testbench top: drives commands and kind-code writes, reports the verdict.
module generational_page_pool_allocator_unit_tb;
    import gppa_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_req        i_item = '0;
    logic        o_result_valid;
    t_res        o_result;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          errors, pending;

    // handles and identities of pages we created, for well-formed follow-ups
    logic [63:0] hnd_q[$];
    logic [31:0] seq_q[$];
    logic [7:0]  lay_q[$];
    logic [31:0] pg_q[$];
    logic [7:0]  cur_kind = KIND_RESET;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    generational_page_pool_allocator_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .o_result_valid(o_result_valid), .o_result(o_result), .psel(psel),
        .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    generational_page_pool_allocator_unit_chk u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy), .i_item(i_item),
        .i_result_valid(o_result_valid), .i_result(o_result), .i_psel(psel),
        .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready), .i_paddr(paddr),
        .i_pwdata(pwdata), .o_errors(errors), .o_pending(pending)
    );

    // capture reserve/find returns to build later commands
    always @(posedge i_clk)
        if (i_rst_n && o_result_valid && o_result.found && hnd_q.size() < 64) begin
            hnd_q.push_back(o_result.out_handle);
            seq_q.push_back(o_result.out_sequence);
            lay_q.push_back({2'b0, o_result.out_layer});
            pg_q.push_back(o_result.out_page_num);
        end

    // start stays high across a zero gap, so the next word can go in the result cycle
    task automatic send_word(t_req q);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        i_item <= q;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_kind(logic [7:0] k);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0;
        pwdata <= {16'($urandom_range(0, 65535)), 8'h00, k};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        cur_kind = k;
        hnd_q.delete(); seq_q.delete(); lay_q.delete(); pg_q.delete();
    endtask

    function automatic t_req rand_noise();
        t_req q;
        logic [287:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom};
        q = raw[$bits(t_req)-1:0];
        return q;
    endfunction

    function automatic t_req make_cmd(t_cmd c, logic [31:0] sq, logic [7:0] ly,
                                      logic [31:0] pg, logic [63:0] h);
        t_req q;
        q = rand_noise();
        q.command = c;
        q.sequence_req = sq; q.layer_index = ly; q.page_num = pg; q.page_handle = h;
        return q;
    endfunction

    // well-formed command, mostly on known pages with small id spaces
    task automatic send_formed;
        t_req q;
        int k, j;
        t_cmd c;
        c = t_cmd'($urandom_range(0, 10));
        q = make_cmd(c, 32'($urandom_range(1, 4)), 8'($urandom_range(0, 3)),
                     32'($urandom_range(0, 7)),
                     {cur_kind, 24'($urandom_range(0, 255)), 32'($urandom_range(0, 3))});
        if (hnd_q.size() > 0 && c != CMD_RESERVE) begin
            k = $urandom_range(0, hnd_q.size() - 1);
            q.sequence_req = seq_q[k]; q.layer_index = lay_q[k];
            q.page_num = pg_q[k]; q.page_handle = hnd_q[k];
            j = $urandom_range(0, hnd_q.size() - 1);
            q.repl_sequence = seq_q[j]; q.repl_layer = lay_q[j];
            q.repl_page = pg_q[j]; q.repl_handle = hnd_q[j];
            if ($urandom_range(0, 1)) begin
                q.repl_sequence = seq_q[k]; q.repl_layer = lay_q[k];
                q.repl_page = pg_q[k];
            end
            if ($urandom_range(0, 15) == 0) q.page_handle[0] ^= 1'b1;
            if (c == CMD_RELEASE || c == CMD_ROLLBACK || c == CMD_COW_PUBLISH ||
                c == CMD_SEQ_RELEASE) begin
                if ($urandom_range(0, 1)) begin
                    hnd_q.delete(k); seq_q.delete(k); lay_q.delete(k); pg_q.delete(k);
                end
            end
        end
        send_word(q);
    endtask

    initial begin
        t_req q;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every command, field extremes, invalid ids, bad kinds/slots
        send_word(make_cmd(CMD_RESERVE, 32'hFFFF_FFFF, 8'd42, 32'hFFFF_FFFF, '0));
        send_word(make_cmd(CMD_RESERVE, 32'd0, 8'd1, 32'd0, '0));
        send_word(make_cmd(CMD_RESERVE, 32'd5, 8'd43, 32'd0, '0));
        send_word(make_cmd(CMD_RESERVE, 32'd5, 8'hFF, 32'd0, '0));
        send_word(make_cmd(CMD_RESERVE, 32'd1, 8'd0, 32'd0, '0));
        send_word(make_cmd(CMD_RESERVE, 32'd1, 8'd0, 32'd0, '0));
        send_word(make_cmd(CMD_FIND, 32'd1, 8'd0, 32'd0, '0));
        send_word(make_cmd(CMD_PUBLISH, 32'd1, 8'd0, 32'd0, {8'd4, 24'd1, 32'd1}));
        send_word(make_cmd(CMD_CHK_PUBLISH, 32'd1, 8'd0, 32'd0, {8'd4, 24'd1, 32'd1}));
        send_word(make_cmd(CMD_PUBLISH, 32'd1, 8'd0, 32'd0, {8'd4, 24'd256, 32'd1}));
        send_word(make_cmd(CMD_PUBLISH, 32'd1, 8'd0, 32'd0, {8'd5, 24'd1, 32'd1}));
        send_word(make_cmd(CMD_PUBLISH, 32'd1, 8'd0, 32'd0, {8'd4, 24'hFF_FFFF, 32'd1}));
        send_word(make_cmd(CMD_PUBLISH, 32'd1, 8'd0, 32'd0, {8'd4, 24'd1, 32'd2}));
        send_word(make_cmd(CMD_PUBLISH, 32'd1, 8'd0, 32'd0, {8'd4, 24'd1, 32'd1}));
        send_word(make_cmd(CMD_FIND, 32'd1, 8'd0, 32'd0, '0));
        send_word(make_cmd(CMD_FIND, 32'd9, 8'd0, 32'd0, '0));
        q = make_cmd(CMD_RESERVE_COW, 32'd1, 8'd0, 32'd0, {8'd4, 24'd1, 32'd1});
        send_word(q);
        q = make_cmd(CMD_CHK_COW_PUB, 32'd1, 8'd0, 32'd0, {8'd4, 24'd1, 32'd1});
        q.repl_sequence = 32'd1; q.repl_layer = 8'd0; q.repl_page = 32'd0;
        q.repl_handle = {8'd4, 24'd1, 32'd1};
        send_word(q);
        q.repl_handle = {8'd4, 24'd2, 32'd1};
        send_word(q);
        q.command = CMD_COW_PUBLISH;
        send_word(q);
        send_word(make_cmd(CMD_CHK_SEQ_REL, 32'd0, 8'd0, 32'd0, '0));
        send_word(make_cmd(CMD_RELEASE, 32'd1, 8'd0, 32'd0, {8'd4, 24'd2, 32'd1}));
        send_word(make_cmd(CMD_SEQ_RELEASE, 32'hFFFF_FFFF, 8'd0, 32'd0, '0));
        send_word(make_cmd(CMD_ROLLBACK, 32'd0, 8'd0, 32'd0, '1));
        for (int c = 11; c < 16; c++) begin
            q = rand_noise(); q.command = 4'(c);
            send_word(q);
        end
        drain();

        // random phases with several kind codes, extremes included
        for (int ph = 0; ph < 5; ph++) begin
            if (ph == 1) write_kind(8'hFF);
            else if (ph == 2) write_kind(8'h00);
            else if (ph > 2) write_kind(8'($urandom_range(0, 255)));
            for (int n = 0; n < 380; n++) begin
                if ($urandom_range(0, 9) == 0) send_word(rand_noise());
                else if ($urandom_range(0, 4) == 0)
                    send_word(make_cmd(CMD_RESERVE, 32'($urandom_range(1, 4)),
                                       8'($urandom_range(0, 3)),
                                       32'($urandom_range(0, 7)), '0));
                else send_formed();
            end
            drain();
        end

        if (errors == 0) $display("generational_page_pool_allocator_unit_tb: clean");
        else $display("generational_page_pool_allocator_unit_tb: errors");
        $finish;
    end

    initial begin
        #20000000;
        $display("generational_page_pool_allocator_unit_tb: errors");
        $finish;
    end
endmodule

FILE: generational_page_pool_allocator_unit.f
hw/rtl/gppa_pkg.sv
hw/rtl/gppa_slot_mem.sv
hw/rtl/gppa_cfg.sv
hw/rtl/generational_page_pool_allocator_unit.sv
bench/generational_page_pool_allocator_unit_chk.sv
bench/generational_page_pool_allocator_unit_tb.sv
